// ===== hdl/ecd_pkg.sv =====
// shared types and constants of the binary cross erode/dilate block
// no dependencies; used by ecd_resq and the top level by scoped names

package ecd_pkg;

  // default size limits, handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // smallest frame edge the block works on
  localparam int MIN_SIZE = 3;

  // fixed field widths
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int CFG_D_W   = 13;
  localparam int REG_IDX_W = 2;
  localparam int COL_OUT_W = 10;
  localparam int ROW_OUT_W = 12;

  // register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_MODE_EXPAND  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // register values after reset
  localparam logic               MODE_RESET   = 1'b1;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd768;

  // cells of the window chain (center and left column)
  localparam int WIN_CELLS = 2;

  // entries of the result queue, a power of two
  localparam int RESQ_DEPTH = 4;

  // one result item
  typedef struct packed {
    logic                 pixel;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
  } ecd_res_t;

  // up to two results handed to the queue in one cycle, first one first
  typedef struct packed {
    logic     v0;
    ecd_res_t r0;
    logic     v1;
    ecd_res_t r1;
  } ecd_push_t;

endpackage

// ===== hdl/ecd_ram.sv =====
// generic single-write, single-read RAM with registered read data
// no dependencies

module ecd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ecd_cell.sv =====
// one column cell of the window chain: holds the middle-row pixel of one
// column, hands it to its left neighbor on each step and folds it into the
// running and/or of the cross neighborhood; no package dependencies

module ecd_cell (
  input  logic clk,
  input  logic shift,
  input  logic din,
  input  logic mode_expand,
  input  logic acc_in,
  output logic dout,
  output logic acc_out
);

  // pixel of this column, taken from the right neighbor on each step
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

  // expand: any black makes black (and); shrink: any white makes white (or)
  assign acc_out = mode_expand ? (acc_in & dout) : (acc_in | dout);

endmodule

// ===== hdl/ecd_resq.sv =====
// result queue: small register queue taking up to two result items a cycle
// and giving one; depends on ecd_pkg

module ecd_resq (
  input  logic                clk,
  input  logic                rst,
  input  ecd_pkg::ecd_push_t  push,
  input  logic                pop,
  output ecd_pkg::ecd_res_t   head,
  output logic                nonempty,
  output logic                room2
);

  localparam int DEPTH = ecd_pkg::RESQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ecd_pkg::ecd_res_t mem [DEPTH];
  logic [PW-1:0]     wp;
  logic [PW-1:0]     wp1;
  logic [PW-1:0]     rp;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  assign wp1 = wp + PW'(1);
  assign count_next = count + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);

  // storage, second item packs behind the first
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp] <= push.r0;
    end
    if (push.v1) begin
      if (push.v0) begin
        mem[wp1] <= push.r1;
      end else begin
        mem[wp] <= push.r1;
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push.v0) + PW'(push.v1);
      rp    <= rp + PW'(pop);
      count <= count_next;
    end
  end

  assign head     = mem[rp];
  assign nonempty = (count != '0);
  assign room2    = (count <= CNT_W'(DEPTH - 2));

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue over its depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push.v0 || push.v1) |-> room2)
    else $error("result pushed without room for two");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("result popped from empty queue");

endmodule

// ===== hdl/binary_cross_erode_dilate.sv =====
// top level of the binary cross erode/dilate block
// depends on ecd_pkg, ecd_ram, ecd_cell and ecd_resq
//
// Usage: pixels enter in raster order on in_valid/in_stall with pixel_in
// (1 white, 0 black); an item is taken at a clock edge with in_valid high
// and in_stall low. Filtered pixels leave on out_valid/out_stall with
// pixel_out, out_column, out_row and frame_last. A pixel of row 0 gives the
// white border pixel of row 0, a pixel of row 1 gives nothing, a pixel of
// row y >= 2 gives the filtered pixel of row y-1, and a pixel of the last
// row also gives its own white border pixel; frame_last marks the final one.
// Configuration (mode_expand, image_width, image_height) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no item is in
// flight, the block does not enforce it. Items pass the window stage, then
// the result queue. Throughput: one item per cycle while the queue has room
// for two results; each last-row item gives two results on the single port.
// Reset clears the counters, the pipeline stage and the result queue and
// loads the register defaults; the two line RAMs are not cleared and hold
// nothing meaningful until the first rows have passed.
// A stalled receiver fills a four-entry result queue; the input then stalls
// while the queue has fewer than two free entries and the window stage is full.

module binary_cross_erode_dilate #(
  parameter int MAX_WIDTH  = ecd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ecd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              cfg_we,
  input  logic [ecd_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [ecd_pkg::CFG_D_W-1:0]       cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              pixel_in,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              pixel_out,
  output logic [ecd_pkg::COL_OUT_W-1:0]     out_column,
  output logic [ecd_pkg::ROW_OUT_W-1:0]     out_row,
  output logic                              frame_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = (ecd_pkg::IMG_W_W > CW + 1) ? ecd_pkg::IMG_W_W : CW + 1;
  localparam int HW  = (ecd_pkg::IMG_H_W > RW + 1) ? ecd_pkg::IMG_H_W : RW + 1;
  localparam int COW = ecd_pkg::COL_OUT_W;
  localparam int ROW = ecd_pkg::ROW_OUT_W;
  localparam int WIN = ecd_pkg::WIN_CELLS;

  // item held in the window stage while the line RAM data arrives
  typedef struct packed {
    logic [CW-1:0]  col;
    logic [COW-1:0] col_out;
    logic           pix;
    logic           mode;
    logic           v0;
    logic           filt;
    logic [ROW-1:0] row0;
    logic           v1;
    logic [ROW-1:0] row1;
    logic           last1;
  } s1_t;

  // configuration registers
  logic                        mode_expand;
  logic [ecd_pkg::IMG_W_W-1:0] image_width;
  logic [ecd_pkg::IMG_H_W-1:0] image_height;

  // position of the next input item
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  logic [WW-1:0] w_cfg;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] w_last;
  logic [HW-1:0] h_cfg;
  logic [HW-1:0] h_eff;
  logic [HW-1:0] h_last;
  logic          last_col;
  logic          last_row;
  logic          row_lt_h;
  logic          row_ge2;
  logic [CW-1:0] next_col;
  logic          in_acc;

  s1_t           s1;
  logic          s1_valid;
  logic          s1_adv;

  logic          older_rd;
  logic          newer_rd;
  logic [WIN:0]  tap;
  logic [WIN:0]  acc;

  ecd_pkg::ecd_push_t push;
  ecd_pkg::ecd_res_t  head;
  logic               q_nonempty;
  logic               q_room2;
  logic               pop;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_expand  <= ecd_pkg::MODE_RESET;
      image_width  <= ecd_pkg::WIDTH_RESET;
      image_height <= ecd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecd_pkg::REG_MODE_EXPAND:  mode_expand  <= cfg_data[0];
        ecd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[ecd_pkg::IMG_W_W-1:0];
        ecd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[ecd_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to the supported range
  always_comb begin
    w_cfg = WW'(image_width);
    if (w_cfg < WW'(ecd_pkg::MIN_SIZE)) begin
      w_eff = WW'(ecd_pkg::MIN_SIZE);
    end else if (w_cfg > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    h_cfg = HW'(image_height);
    if (h_cfg < HW'(ecd_pkg::MIN_SIZE)) begin
      h_eff = HW'(ecd_pkg::MIN_SIZE);
    end else if (h_cfg > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
    w_last = w_eff - WW'(1);
    h_last = h_eff - HW'(1);
  end

  // position decode of the incoming item
  assign last_col = (WW'(col_count) >= w_last);
  assign last_row = (HW'(row_count) >= h_last);
  assign row_lt_h = (HW'(row_count) < h_eff);
  assign row_ge2  = (row_count >= RW'(2));
  assign next_col = last_col ? '0 : col_count + CW'(1);

  // handshake: the stage takes a new item whenever it moves on or is empty
  assign s1_adv   = s1_valid && q_room2;
  assign in_stall = s1_valid && !q_room2;
  assign in_acc   = in_valid && !in_stall;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // window stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // window stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.col     <= col_count;
      s1.col_out <= COW'(col_count);
      s1.pix     <= pixel_in;
      s1.mode    <= mode_expand;
      s1.v0      <= (row_count == '0) || row_ge2;
      s1.filt    <= row_ge2 && (col_count != '0) && !last_col && row_lt_h;
      s1.row0    <= (row_count == '0) ? '0 : ROW'(row_count - RW'(1));
      s1.v1      <= last_row;
      s1.row1    <= ROW'(row_count);
      s1.last1   <= last_col;
    end
  end

  // line stores: older row read at this column, newer row one column ahead
  ecd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_older (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1.col),
    .wdata (tap[1]),
    .re    (in_acc),
    .raddr (col_count),
    .rdata (older_rd)
  );

  ecd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_newer (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1.col),
    .wdata (s1.pix),
    .re    (in_acc),
    .raddr (next_col),
    .rdata (newer_rd)
  );

  // window chain: right column from the RAM, then center and left cells
  assign tap[0] = newer_rd;
  assign acc[0] = s1.mode ? (newer_rd & older_rd & s1.pix)
                          : (newer_rd | older_rd | s1.pix);

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    ecd_cell u_cell (
      .clk         (clk),
      .shift       (s1_adv),
      .din         (tap[i]),
      .mode_expand (s1.mode),
      .acc_in      (acc[i]),
      .dout        (tap[i+1]),
      .acc_out     (acc[i+1])
    );
  end

  // results of the item in the window stage
  always_comb begin
    push.v0        = s1_adv && s1.v0;
    push.r0.pixel  = s1.filt ? acc[WIN] : 1'b1;
    push.r0.column = s1.col_out;
    push.r0.row    = s1.row0;
    push.r0.last   = 1'b0;
    push.v1        = s1_adv && s1.v1;
    push.r1.pixel  = 1'b1;
    push.r1.column = s1.col_out;
    push.r1.row    = s1.row1;
    push.r1.last   = s1.last1;
  end

  // result queue and output port
  ecd_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty),
    .room2    (q_room2)
  );

  assign out_valid  = q_nonempty;
  assign pop        = out_valid && !out_stall;
  assign pixel_out  = head.pixel;
  assign out_column = head.column;
  assign out_row    = head.row;
  assign frame_last = head.last;

  // checks
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_col |=> col_count == '0)
    else $error("column counter did not wrap after last column");

  a_last_white: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> pixel_out)
    else $error("final item of the frame is not a white border pixel");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1.col))
    else $error("window stage lost a held item");

endmodule
